/* rtl/zts_pkg.sv */
// ----------------------------------------------------------------------------
// zts_pkg
// Shared types, constants and the CRC-32 table function of the stream cipher.
// ----------------------------------------------------------------------------
package zts_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] KEY_MULT    = 32'h08088405;
    localparam logic [31:0] RESET_KEY_A = 32'h12345678;
    localparam logic [31:0] RESET_KEY_B = 32'h23456789;
    localparam logic [31:0] RESET_KEY_C = 32'h34567890;

    localparam logic [1:0] CFG_KEY_ZERO = 2'd0;
    localparam logic [1:0] CFG_KEY_ONE  = 2'd1;
    localparam logic [1:0] CFG_KEY_TWO  = 2'd2;

    localparam logic KIND_ABSORB  = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KS,
        ST_A,
        ST_B,
        ST_C
    } t_state;

    typedef struct packed {
        logic [31:0] key_two;
        logic [31:0] key_one;
        logic [31:0] key_zero;
        logic [7:0]  out_byte;
    } t_result;

    // Reflected CRC-32 table entry, resolved to constant logic by synthesis
    function automatic logic [31:0] crc_entry(input logic [7:0] idx);
        logic [31:0] v;
        v = {24'd0, idx};
        for (int i = 0; i < 8; i++) begin
            v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
        end
        return v;
    endfunction

endpackage

/* rtl/zts_crc_unit.sv */
// ----------------------------------------------------------------------------
// zts_crc_unit
// One CRC-32 byte step: (crc >> 8) ^ table[(crc ^ byte) & 0xFF].
// ----------------------------------------------------------------------------
module zts_crc_unit (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    logic [7:0] w_idx;

    assign w_idx = i_crc[7:0] ^ i_byte;
    assign o_crc = {8'd0, i_crc[31:8]} ^ zts_pkg::crc_entry(w_idx);

endmodule

/* rtl/zts_mul_unit.sv */
// ----------------------------------------------------------------------------
// zts_mul_unit
// Shared 32x32 multiplier, low 32 bits of the product registered on enable.
// ----------------------------------------------------------------------------
module zts_mul_unit (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_prod
);

    logic [31:0] w_low;
    logic [31:0] r_prod;

    assign w_low = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_low;
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/zip_traditional_stream_cipher.sv */
// ----------------------------------------------------------------------------
// zip_traditional_stream_cipher
// Traditional PKZIP three-key stream cipher, one byte per beat.
// ----------------------------------------------------------------------------
// Each input beat either absorbs a password byte (tuser kind 0) or decrypts a
// ciphertext byte (tuser kind 1); tuser restart reloads the keys from the
// configured initial values first. Every input beat gives exactly one output
// beat carrying the plaintext byte (zero when absorbing) and the three keys
// after the step. A ciphertext beat steps through states KS, A, B and C and a
// password beat through A, B and C, and a beat is taken only in idle: a single
// multiplier serves both the keystream product and the key_one update, and one
// CRC unit serves both CRC updates, in sequence. Output beats sit in a register,
// so the next input is taken while a result still waits; the final step stalls
// only if that register is still full.
// ----------------------------------------------------------------------------
module zip_traditional_stream_cipher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]   s_axis_tuser,   // [0] kind, [1] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // [7:0] out_byte, [39:8] key_zero,
                                         // [71:40] key_one, [103:72] key_two
);

    zts_pkg::t_state  r_state, n_state;
    zts_pkg::t_result r_result;

    logic [31:0] r_init_a, r_init_b, r_init_c;
    logic [31:0] r_key_a, r_key_b, r_key_c;
    logic        r_kind;
    logic [7:0]  r_data;
    logic [7:0]  r_out_byte;
    logic        r_out_valid;

    logic        w_accept;
    logic        w_out_free;
    logic        w_load_out;
    logic [15:0] w_t;
    logic [7:0]  w_plain;
    logic [31:0] w_key_b_new;
    logic        w_mul_en;
    logic [31:0] w_mul_a, w_mul_b, w_prod;
    logic [31:0] w_crc_in, w_crc_out;
    logic [7:0]  w_crc_byte;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_load_out  = (r_state == zts_pkg::ST_C) && w_out_free;
    assign w_t         = r_key_c[15:0] | 16'h0002;
    assign w_plain     = (r_kind == zts_pkg::KIND_DECRYPT) ? (r_data ^ w_prod[15:8]) : r_data;
    assign w_key_b_new = w_prod + 32'd1;

    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = r_key_b + {24'd0, r_key_a[7:0]};
        w_mul_b  = zts_pkg::KEY_MULT;
        case (r_state)
            zts_pkg::ST_KS: begin
                w_mul_en = 1'b1;
                w_mul_a  = {16'd0, w_t};
                w_mul_b  = {16'd0, w_t ^ 16'h0001};
            end
            zts_pkg::ST_B: begin
                w_mul_en = 1'b1;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_state == zts_pkg::ST_C) begin
            w_crc_in   = r_key_c;
            w_crc_byte = w_key_b_new[31:24];
        end else begin
            w_crc_in   = r_key_a;
            w_crc_byte = w_plain;
        end
    end

    zts_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    zts_crc_unit u_crc (
        .i_crc  (w_crc_in),
        .i_byte (w_crc_byte),
        .o_crc  (w_crc_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            zts_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser[0] == zts_pkg::KIND_DECRYPT) ?
                              zts_pkg::ST_KS : zts_pkg::ST_A;
                end
            end
            zts_pkg::ST_KS: n_state = zts_pkg::ST_A;
            zts_pkg::ST_A:  n_state = zts_pkg::ST_B;
            zts_pkg::ST_B:  n_state = zts_pkg::ST_C;
            zts_pkg::ST_C: begin
                if (w_out_free) begin
                    n_state = zts_pkg::ST_IDLE;
                end
            end
            default: n_state = zts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_a <= zts_pkg::RESET_KEY_A;
            r_init_b <= zts_pkg::RESET_KEY_B;
            r_init_c <= zts_pkg::RESET_KEY_C;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                zts_pkg::CFG_KEY_ZERO: r_init_a <= i_cfg_data;
                zts_pkg::CFG_KEY_ONE:  r_init_b <= i_cfg_data;
                zts_pkg::CFG_KEY_TWO:  r_init_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a <= zts_pkg::RESET_KEY_A;
            r_key_b <= zts_pkg::RESET_KEY_B;
            r_key_c <= zts_pkg::RESET_KEY_C;
        end else begin
            case (r_state)
                zts_pkg::ST_IDLE: begin
                    if (w_accept && s_axis_tuser[1]) begin
                        r_key_a <= r_init_a;
                        r_key_b <= r_init_b;
                        r_key_c <= r_init_c;
                    end
                end
                zts_pkg::ST_A: r_key_a <= w_crc_out;
                zts_pkg::ST_C: begin
                    if (w_out_free) begin
                        r_key_b <= w_key_b_new;
                        r_key_c <= w_crc_out;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= s_axis_tuser[0];
            r_data <= s_axis_tdata;
        end
        if (r_state == zts_pkg::ST_A) begin
            r_out_byte <= (r_kind == zts_pkg::KIND_DECRYPT) ? w_plain : 8'd0;
        end
        if (w_load_out) begin
            r_result.out_byte <= r_out_byte;
            r_result.key_zero <= r_key_a;
            r_result.key_one  <= w_key_b_new;
            r_result.key_two  <= w_crc_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == zts_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;

    a_absorb_skips_ks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (s_axis_tuser[0] == zts_pkg::KIND_ABSORB) |=> r_state == zts_pkg::ST_A)
        else $error("absorb beat entered keystream step");

    a_load_from_c : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == zts_pkg::ST_C)
        else $error("output loaded outside final step");

    a_absorb_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out && (r_kind == zts_pkg::KIND_ABSORB) |=> m_axis_tdata[7:0] == 8'd0)
        else $error("absorb beat gave non-zero byte");

    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != zts_pkg::ST_IDLE) |=> !$past(w_accept))
        else $error("beat accepted while busy");

endmodule
